FILE: design/mlt_pkg.sv
// Package for the MAC learning table: sizes, payload structs and the
// controller/datapath command struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mlt_pkg;
  localparam int BUCKETS   = 8;
  localparam int WAYS      = 4;
  localparam int NUM_PORTS = 16;
  localparam int ENTRIES   = BUCKETS * WAYS;
  localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int MAC_W     = 48;
  localparam int PORT_W    = 4;
  localparam int AGE_W     = 6;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 6'd30;
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] in_port;
  } mlt_in_t;

  typedef struct packed {
    logic              flood;
    logic [PORT_W-1:0] out_port;
    logic              src_known;
    logic              evicted;
    logic [AGE_W-1:0]  expired_count;
  } mlt_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the input item, clear results
    logic frame_exec; // frame lookup/learn over the source and destination buckets
    logic tick_step;  // age the entry at tick_idx
    logic [IDX_W-1:0] tick_idx;
  } mlt_cmd_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [MAC_W-1:0] mac);
    return BKT_W'(mac[7:0] % BUCKETS);
  endfunction
endpackage
`default_nettype wire

FILE: design/mlt_dp.sv
// Datapath of the MAC learning table: entry storage, lookup, victim
// choice, aging and the result register. Depends on mlt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlt_dp import mlt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire mlt_in_t    item,
  input  wire mlt_cmd_t   cmd,
  input  wire logic [AGE_W-1:0] age_limit,
  output mlt_out_t        res
);
  logic [ENTRIES-1:0]     vld_r, vld_nxt;
  logic [MAC_W-1:0]       mac_r  [ENTRIES];
  logic [PORT_W-1:0]      port_r [ENTRIES];
  logic [AGE_W-1:0]       age_r  [ENTRIES];
  mlt_in_t                itm_r;
  mlt_out_t               res_r, res_nxt;

  logic [BKT_W-1:0] sb, db;
  logic             d_hit, s_hit, free_f;
  logic [WAY_W-1:0] d_way, s_way, vic_way;
  logic [AGE_W-1:0] vic_age, aged;
  logic [IDX_W-1:0] d_idx, s_idx, v_idx;
  logic [AGE_W-1:0] way_age [WAYS];

  // Lookup within the two buckets of the captured frame.
  always_comb begin
    sb = bucket_of(itm_r.src_mac);
    db = bucket_of(itm_r.dst_mac);
    d_hit = 1'b0; s_hit = 1'b0; free_f = 1'b0;
    d_way = '0; s_way = '0; vic_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vld_r[IDX_W'(db * WAYS + w)] && mac_r[IDX_W'(db * WAYS + w)] == itm_r.dst_mac) begin
        d_hit = 1'b1; d_way = WAY_W'(w);
      end
      if (vld_r[IDX_W'(sb * WAYS + w)] && mac_r[IDX_W'(sb * WAYS + w)] == itm_r.src_mac) begin
        s_hit = 1'b1; s_way = WAY_W'(w);
      end
    end
    // The destination hit has its age cleared before the victim is chosen.
    for (int w = 0; w < WAYS; w++) begin
      way_age[w] = (d_hit && db == sb && d_way == WAY_W'(w)) ? '0
                                                             : age_r[IDX_W'(sb * WAYS + w)];
    end
    vic_age = way_age[0];
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vld_r[IDX_W'(sb * WAYS + w)]) begin
        free_f = 1'b1; vic_way = WAY_W'(w);
      end
    end
    if (!free_f) begin
      for (int w = 1; w < WAYS; w++) begin
        if (way_age[w] > vic_age) begin
          vic_age = way_age[w]; vic_way = WAY_W'(w);
        end
      end
    end
    d_idx = IDX_W'(db * WAYS + d_way);
    s_idx = IDX_W'(sb * WAYS + s_way);
    v_idx = IDX_W'(sb * WAYS + vic_way);
    aged  = (age_r[cmd.tick_idx] < AGE_MAX) ? age_r[cmd.tick_idx] + 1'b1
                                            : age_r[cmd.tick_idx];
  end

  always_comb begin
    vld_nxt = vld_r;
    res_nxt = res_r;
    if (cmd.load) begin
      res_nxt = '0;
    end else if (cmd.frame_exec) begin
      res_nxt.flood     = !d_hit;
      res_nxt.out_port  = d_hit ? port_r[d_idx] : itm_r.in_port;
      res_nxt.src_known = s_hit;
      if (32'(itm_r.in_port) < NUM_PORTS && !s_hit) begin
        vld_nxt[v_idx]  = 1'b1;
        res_nxt.evicted = !free_f;
      end
    end else if (cmd.tick_step && vld_r[cmd.tick_idx] && aged >= age_limit) begin
      vld_nxt[cmd.tick_idx] = 1'b0;
      if (res_r.expired_count < AGE_MAX) begin
        res_nxt.expired_count = res_r.expired_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    res_r <= res_nxt;
    if (cmd.load) begin
      itm_r <= item;
    end
    if (cmd.frame_exec) begin
      // Destination refresh first; source update overrides on the same entry.
      if (d_hit) begin
        age_r[d_idx] <= '0;
      end
      if (32'(itm_r.in_port) < NUM_PORTS) begin
        if (s_hit) begin
          age_r[s_idx]  <= '0;
          port_r[s_idx] <= itm_r.in_port;
        end else begin
          age_r[v_idx]  <= '0;
          port_r[v_idx] <= itm_r.in_port;
          mac_r[v_idx]  <= itm_r.src_mac;
        end
      end
    end
    if (cmd.tick_step && vld_r[cmd.tick_idx]) begin
      age_r[cmd.tick_idx] <= aged;
    end
  end

  assign res = res_r;
endmodule
`default_nettype wire

FILE: design/mlt_ctrl.sv
// Controller of the MAC learning table: handshakes and the sequencer that
// runs a frame in one step or walks the table for a tick. Depends on mlt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlt_ctrl import mlt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic in_op,
  output logic      out_valid,
  input  wire logic out_ready,
  output mlt_cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FRAME = 4'b0010,
    S_TICK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;
  state_t st_r, st_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_DONE);

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.tick_idx = idx_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          idx_nxt = '0;
          st_nxt = (in_op == OP_TICK) ? S_TICK : S_FRAME;
        end
      end
      S_FRAME: begin
        cmd.frame_exec = 1'b1;
        st_nxt = S_DONE;
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (32'(idx_r) == ENTRIES - 1) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      idx_r <= '0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FRAME |=> st_r == S_DONE) else $error("frame did not finish");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

FILE: design/mac_learning_table.sv
// Top level of the MAC learning table: handshake controller and datapath.
// Depends on mlt_pkg, mlt_ctrl and mlt_dp.
`timescale 1ns / 1ps
`default_nettype none
// A set-associative learning table of BUCKETS x WAYS entries for a switch.
// Each item yields one result. A frame item is captured, looked up and
// learned in one step over the source and destination buckets, and its
// result is then offered; with no stalls the next item is accepted after
// the result handoff (capture, lookup/learn, result handoff). A tick item's
// result is offered once the aging walk, which visits one entry per cycle,
// has covered all ENTRIES entries. One item is worked at a time, and
// in_ready returns once the result item is taken; a stalled result holds
// off the next item for as long as it waits.
// age_limit may be changed at any time through cfg_we/cfg_data but should
// only be written while the block is idle.
module mac_learning_table import mlt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mlt_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mlt_out_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [AGE_W-1:0] cfg_data
);
  mlt_cmd_t cmd;
  logic [AGE_W-1:0] age_limit_r;

  // The age limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= AGE_LIMIT_RST;
    end else if (cfg_we) begin
      age_limit_r <= cfg_data;
    end
  end

  mlt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_op(in_data.operation),
    .out_valid, .out_ready, .cmd
  );

  mlt_dp u_dp (
    .clk, .rst_n, .item(in_data), .cmd, .age_limit(age_limit_r), .res(out_data)
  );
endmodule
`default_nettype wire
